[hw/rtl/wsal_pkg.sv]
`timescale 1ns / 1ps

package wsal_pkg;

  localparam int unsigned SENSOR_COUNT = 6;
  localparam int unsigned RPM_W        = 16;
  localparam int unsigned MOTOR_W      = 26;  // 65535 * 600 fits in 26 bits
  localparam int unsigned DIV_W        = 29;  // motor * 10 fits in 29 bits
  localparam int unsigned DIVISOR_W    = 16;
  localparam int unsigned SUM_W        = 19;  // six 16-bit speeds
  localparam int unsigned ACC_W        = 33;

  localparam int unsigned RPM_SCALE   = 600;
  localparam int unsigned RATIO_SCALE = 10;
  localparam int unsigned AVG_DIVISOR = 6;
  localparam logic [16:0] Q16_ONE     = 17'h10000;

  localparam logic [1:0] CFG_TEETH = 2'd0;
  localparam logic [1:0] CFG_RATIO = 2'd1;
  localparam logic [1:0] CFG_COEFF = 2'd2;

  localparam logic [7:0]  TEETH_RESET = 8'd67;
  localparam logic [15:0] RATIO_RESET = 16'd483;
  localparam logic [15:0] COEFF_RESET = 16'd64723;

  typedef struct packed {
    logic [15:0] freq_a;
    logic [15:0] freq_b;
    logic [15:0] freq_c;
    logic [15:0] freq_d;
    logic [15:0] freq_e;
    logic [15:0] freq_f;
  } in_word_t;

  typedef struct packed {
    logic [15:0] wheel_rpm_a;
    logic [15:0] wheel_rpm_b;
    logic [15:0] wheel_rpm_c;
    logic [15:0] wheel_rpm_d;
    logic [15:0] wheel_rpm_e;
    logic [15:0] wheel_rpm_f;
    logic [15:0] average_rpm;
    logic [15:0] filtered_rpm;
  } out_word_t;

  typedef struct packed {
    logic                   start;
    logic [DIV_W-1:0]       dividend;
    logic [DIVISOR_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [DIV_W-1:0]       quotient;
  } div_rsp_t;

endpackage

[hw/rtl/wsal_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module wsal_div (
  input  logic               clk,
  input  logic               rst,
  input  wsal_pkg::div_req_t req,
  output wsal_pkg::div_rsp_t rsp
);
  import wsal_pkg::*;

  localparam logic [4:0] LAST = 5'(DIV_W - 1);

  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] divisor;
  logic [DIV_W-1:0]     quo;
  logic [4:0]           count;
  logic                 busy;
  logic                 done;

  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W+1:0] diff;
  logic                 fits;

  assign shifted = {rem, quo[DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b0, divisor};
  assign fits    = ~diff[DIVISOR_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= ~req.start & busy & (count == LAST);
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 5'd1;
        if (count == LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      quo     <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

[hw/rtl/wheel_speed_average_lowpass_core.sv]
`timescale 1ns / 1ps
// Each word takes 13 divisions on the single bit-serial divider (motor and
//   wheel per sensor, then the average), then the filter and output load.
// A new word is taken only after the last result is loaded for output.
// Reset (rst, synchronous): registers return to 67 / 483 / 64723, the filter
//   state clears to zero, and both channels go idle.
module wheel_speed_average_lowpass_core (
  input  logic                clk,
  input  logic                rst,
  // input words
  input  logic                in_valid,
  output logic                in_ready,
  input  wsal_pkg::in_word_t  in_data,
  // output words
  output logic                out_valid,
  input  logic                out_ready,
  output wsal_pkg::out_word_t out_data,
  // configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import wsal_pkg::*;

  // Sequencer: per wheel, motor division then wheel division; then the
  // average division by six; then two multiply steps (old, new) for the filter.
  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_MOTOR      = 4'd1;
  localparam logic [3:0] S_MOTOR_WAIT = 4'd2;
  localparam logic [3:0] S_WHEEL      = 4'd3;
  localparam logic [3:0] S_WHEEL_WAIT = 4'd4;
  localparam logic [3:0] S_AVG        = 4'd5;
  localparam logic [3:0] S_AVG_WAIT   = 4'd6;
  localparam logic [3:0] S_MUL_OLD    = 4'd7;
  localparam logic [3:0] S_MUL_NEW    = 4'd8;
  localparam logic [3:0] S_DONE       = 4'd9;

  localparam logic [2:0] LAST_WHEEL = 3'(SENSOR_COUNT - 1);

  logic [3:0]  state;
  logic [3:0]  state_next;

  // Configuration registers
  logic [7:0]  teeth;
  logic [15:0] ratio;
  logic [15:0] coeff;

  // Working registers
  logic [15:0]        freq_q  [SENSOR_COUNT];
  logic [RPM_W-1:0]   wheel_q [SENSOR_COUNT];
  logic [2:0]         wheel_idx;
  logic [MOTOR_W-1:0] motor;
  logic [SUM_W-1:0]   sum;
  logic [RPM_W-1:0]   avg;
  logic [RPM_W-1:0]   filt;
  logic [ACC_W-1:0]   acc;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [DIVISOR_W-1:0] teeth_div;
  logic [DIVISOR_W-1:0] ratio_div;
  logic [RPM_W-1:0]     wheel_sat;
  logic [RPM_W-1:0]     avg_fix;
  logic [16:0]          coeff_new;
  logic                 out_free;

  // A zero divisor register counts as one.
  assign teeth_div = (teeth == 8'd0) ? 16'd1 : {8'd0, teeth};
  assign ratio_div = (ratio == 16'd0) ? 16'd1 : ratio;

  assign wheel_sat = (div_rsp.quotient[DIV_W-1:RPM_W] != '0) ? 16'hFFFF
                                                             : div_rsp.quotient[RPM_W-1:0];
  assign avg_fix   = (div_rsp.quotient[RPM_W-1:0] == 16'd0) ? 16'd1
                                                            : div_rsp.quotient[RPM_W-1:0];
  assign coeff_new = Q16_ONE - {1'b0, coeff};
  assign out_free  = ~out_valid | out_ready;

  // Nothing is taken while reset is held.
  assign in_ready  = (state == S_IDLE) & ~rst;
  assign cfg_ready = ~rst;

  // Divider request
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = teeth_div;
    unique case (state)
      S_MOTOR: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'({10'd0, freq_q[0]} * MOTOR_W'(RPM_SCALE));
        div_req.divisor  = teeth_div;
      end
      S_WHEEL: begin
        div_req.start    = 1'b1;
        div_req.dividend = {3'd0, motor} * DIV_W'(RATIO_SCALE);
        div_req.divisor  = ratio_div;
      end
      S_AVG: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(sum);
        div_req.divisor  = DIVISOR_W'(AVG_DIVISOR);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  wsal_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:       if (in_valid) state_next = S_MOTOR;
      S_MOTOR:      state_next = S_MOTOR_WAIT;
      S_MOTOR_WAIT: if (div_rsp.done) state_next = S_WHEEL;
      S_WHEEL:      state_next = S_WHEEL_WAIT;
      S_WHEEL_WAIT: begin
        if (div_rsp.done) state_next = (wheel_idx == LAST_WHEEL) ? S_AVG : S_MOTOR;
      end
      S_AVG:        state_next = S_AVG_WAIT;
      S_AVG_WAIT:   if (div_rsp.done) state_next = S_MUL_OLD;
      S_MUL_OLD:    state_next = S_MUL_NEW;
      S_MUL_NEW:    state_next = S_DONE;
      S_DONE:       if (out_free) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      teeth     <= TEETH_RESET;
      ratio     <= RATIO_RESET;
      coeff     <= COEFF_RESET;
      filt      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_TEETH: teeth <= cfg_data[7:0];
          CFG_RATIO: ratio <= cfg_data;
          CFG_COEFF: coeff <= cfg_data;
          default:   ;
        endcase
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
        filt      <= acc[31:16];
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      freq_q[0] <= in_data.freq_a;
      freq_q[1] <= in_data.freq_b;
      freq_q[2] <= in_data.freq_c;
      freq_q[3] <= in_data.freq_d;
      freq_q[4] <= in_data.freq_e;
      freq_q[5] <= in_data.freq_f;
      wheel_idx <= '0;
      sum       <= '0;
    end
    if (state == S_MOTOR_WAIT && div_rsp.done) begin
      motor <= div_rsp.quotient[MOTOR_W-1:0];
    end
    // Wheel done: shift the frequency line forward, shift the speed in.
    if (state == S_WHEEL_WAIT && div_rsp.done) begin
      for (int i = 0; i < SENSOR_COUNT - 1; i++) begin
        freq_q[i]  <= freq_q[i+1];
        wheel_q[i] <= wheel_q[i+1];
      end
      wheel_q[SENSOR_COUNT-1] <= wheel_sat;
      sum       <= sum + SUM_W'(wheel_sat);
      wheel_idx <= wheel_idx + 3'd1;
    end
    if (state == S_AVG_WAIT && div_rsp.done) begin
      avg <= avg_fix;
    end
    if (state == S_MUL_OLD) begin
      acc <= ACC_W'({16'd0, coeff} * {16'd0, filt});
    end
    if (state == S_MUL_NEW) begin
      acc <= acc + ACC_W'({16'd0, coeff_new} * {17'd0, avg});
    end
    if (state == S_DONE && out_free) begin
      out_data.wheel_rpm_a  <= wheel_q[0];
      out_data.wheel_rpm_b  <= wheel_q[1];
      out_data.wheel_rpm_c  <= wheel_q[2];
      out_data.wheel_rpm_d  <= wheel_q[3];
      out_data.wheel_rpm_e  <= wheel_q[4];
      out_data.wheel_rpm_f  <= wheel_q[5];
      out_data.average_rpm  <= avg;
      out_data.filtered_rpm <= acc[31:16];
    end
  end

endmodule
